// ----- rtl/sps_pkg.sv -----
// sps_pkg: item types and fixed widths for the sphere pair separation pipeline.
// No dependencies.
`default_nettype none
package sps_pkg;

    localparam int POS_W  = 32;
    localparam int RAD_W  = 31;
    localparam int MAG_W  = POS_W + 1;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int SUM_W  = SQ_W + 2;
    localparam int ROOT_W = SUM_W / 2;
    localparam int Q_W    = 32;
    localparam int DEN_W  = Q_W + 1;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_a_x;
        logic signed [POS_W-1:0] pos_a_y;
        logic signed [POS_W-1:0] pos_a_z;
        logic signed [POS_W-1:0] pos_b_x;
        logic signed [POS_W-1:0] pos_b_y;
        logic signed [POS_W-1:0] pos_b_z;
        logic [RAD_W-1:0]        radius_a;
        logic [RAD_W-1:0]        radius_b;
    } t_in;

    typedef struct packed {
        logic signed [POS_W-1:0] corr_x;
        logic signed [POS_W-1:0] corr_y;
        logic signed [POS_W-1:0] corr_z;
        logic                    applied;
    } t_out;

endpackage
`default_nettype wire

// ----- rtl/sphere_pair_separation.sv -----
// sphere_pair_separation: sphere pair overlap correction, fully pipelined.
// Pipeline: 3 front stages, 34 root stages, 2 stages, 32 divide stages, output.
// Throughput one item per cycle; the whole pipe holds while the output item is stalled.
// Synchronous active-low reset clears all valid bits; payload registers are not reset.
// Depends on sps_pkg, sps_sqrt, sps_div.
`default_nettype none
module sphere_pair_separation
    import sps_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    input  wire t_in  i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output t_out      o_out_data
);

    typedef struct packed {
        logic [2:0]          neg;
        logic [2:0][Q_W-1:0] mag;
        logic [Q_W-1:0]      rsum;
    } t_rt_side;

    typedef struct packed {
        logic [2:0] neg;
        logic       applied;
    } t_dv_side;

    logic w_en;
    logic r_out_v;
    t_out r_out;

    assign w_en        = ~(r_out_v & i_out_stall);
    assign o_in_stall  = ~w_en;
    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

    // stage A: deltas and magnitudes
    logic                  r_a_v;
    logic [2:0]            r_a_neg;
    logic [2:0][MAG_W-1:0] r_a_mag;
    logic [Q_W-1:0]        r_a_rsum;
    logic [2:0][MAG_W-1:0] n_a_d;

    always_comb begin
        n_a_d[0] = {i_in_data.pos_b_x[POS_W-1], i_in_data.pos_b_x}
                 - {i_in_data.pos_a_x[POS_W-1], i_in_data.pos_a_x};
        n_a_d[1] = {i_in_data.pos_b_y[POS_W-1], i_in_data.pos_b_y}
                 - {i_in_data.pos_a_y[POS_W-1], i_in_data.pos_a_y};
        n_a_d[2] = {i_in_data.pos_b_z[POS_W-1], i_in_data.pos_b_z}
                 - {i_in_data.pos_a_z[POS_W-1], i_in_data.pos_a_z};
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_a_neg[i] <= n_a_d[i][MAG_W-1];
                r_a_mag[i] <= n_a_d[i][MAG_W-1] ? (MAG_W'(0) - n_a_d[i]) : n_a_d[i];
            end
            r_a_rsum <= {1'b0, i_in_data.radius_a} + {1'b0, i_in_data.radius_b};
        end
    end

    // stage B: squares
    logic                  r_b_v;
    logic [2:0][SQ_W-1:0]  r_b_sq;
    t_rt_side              r_b_side;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_b_sq[i]       <= r_a_mag[i] * r_a_mag[i];
                r_b_side.mag[i] <= r_a_mag[i][Q_W-1:0];
            end
            r_b_side.neg  <= r_a_neg;
            r_b_side.rsum <= r_a_rsum;
        end
    end

    // stage C: sum of squares
    logic              r_c_v;
    logic [SUM_W-1:0]  r_c_sum;
    t_rt_side          r_c_side;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_sum  <= {2'b00, r_b_sq[0]} + {2'b00, r_b_sq[1]} + {2'b00, r_b_sq[2]};
            r_c_side <= r_b_side;
        end
    end

    logic              w_rt_v;
    logic [ROOT_W-1:0] w_rt_dist;
    t_rt_side          w_rt_side;
    logic [$bits(t_rt_side)-1:0] w_rt_side_in;

    assign w_rt_side_in = r_c_side;

    sps_sqrt #(
        .RADIX_W (SUM_W),
        .SIDE_W  ($bits(t_rt_side))
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_c_v),
        .i_rad   (r_c_sum),
        .i_side  (w_rt_side_in),
        .o_valid (w_rt_v),
        .o_root  (w_rt_dist),
        .o_side  (w_rt_side)
    );

    // stage D: penetration and overlap decision
    logic                    r_d_v;
    logic                    r_d_applied;
    logic [Q_W-1:0]          r_d_pen;
    logic [DEN_W-1:0]        r_d_den;
    logic [2:0]              r_d_neg;
    logic [2:0][Q_W-1:0]     r_d_mag;
    logic signed [ROOT_W:0]  w_pen;

    assign w_pen = $signed({{(ROOT_W+1-Q_W){1'b0}}, w_rt_side.rsum})
                 - $signed({1'b0, w_rt_dist});

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d_applied <= (w_rt_dist != '0) && !w_pen[ROOT_W] && (w_pen != '0);
            r_d_pen     <= w_pen[Q_W-1:0];
            r_d_den     <= {w_rt_dist[Q_W-1:0], 1'b0};
            r_d_neg     <= w_rt_side.neg;
            r_d_mag     <= w_rt_side.mag;
        end
    end

    // stage E: numerators
    logic                  r_e_v;
    logic [2*Q_W-1:0]      r_e_num [3];
    logic [DEN_W-1:0]      r_e_den;
    t_dv_side              r_e_side;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) r_e_num[i] <= r_d_mag[i] * r_d_pen;
            r_e_den          <= r_d_den;
            r_e_side.neg     <= r_d_neg;
            r_e_side.applied <= r_d_applied;
        end
    end

    logic                      w_dv_v;
    logic [Q_W-1:0]            w_dv_q [3];
    logic [$bits(t_dv_side)-1:0] w_dv_side_in;
    t_dv_side                  w_dv_side;

    assign w_dv_side_in = r_e_side;

    sps_div #(
        .LANES  (3),
        .QW     (Q_W),
        .DW     (DEN_W),
        .SIDE_W ($bits(t_dv_side))
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_e_v),
        .i_num   (r_e_num),
        .i_den   (r_e_den),
        .i_side  (w_dv_side_in),
        .o_valid (w_dv_v),
        .o_q     (w_dv_q),
        .o_side  (w_dv_side)
    );

    // output stage: sign and zero when not overlapping
    logic [2:0][Q_W-1:0] w_corr;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (!w_dv_side.applied) begin
                w_corr[i] = '0;
            end else if (w_dv_side.neg[i]) begin
                w_corr[i] = Q_W'(0) - w_dv_q[i];
            end else begin
                w_corr[i] = w_dv_q[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out.corr_x  <= w_corr[0];
            r_out.corr_y  <= w_corr[1];
            r_out.corr_z  <= w_corr[2];
            r_out.applied <= w_dv_side.applied;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v   <= 1'b0;
            r_b_v   <= 1'b0;
            r_c_v   <= 1'b0;
            r_d_v   <= 1'b0;
            r_e_v   <= 1'b0;
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_a_v   <= i_in_valid;
            r_b_v   <= r_a_v;
            r_c_v   <= r_b_v;
            r_d_v   <= w_rt_v;
            r_e_v   <= r_d_v;
            r_out_v <= w_dv_v;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/sps_sqrt.sv -----
// sps_sqrt: pipelined integer square root, one result bit per stage.
// Carries an opaque sideband alongside each item. No package dependencies.
`default_nettype none
module sps_sqrt #(
    parameter int RADIX_W = 68,
    parameter int SIDE_W  = 8
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_en,
    input  wire logic                   i_valid,
    input  wire logic [RADIX_W-1:0]     i_rad,
    input  wire logic [SIDE_W-1:0]      i_side,
    output logic                        o_valid,
    output logic [RADIX_W/2-1:0]        o_root,
    output logic [SIDE_W-1:0]           o_side
);

    localparam int NST   = RADIX_W / 2;
    localparam int REM_W = NST + 3;

    logic               r_v    [NST];
    logic [REM_W-1:0]   r_rem  [NST];
    logic [NST-1:0]     r_root [NST];
    logic [RADIX_W-1:0] r_rad  [NST];
    logic [SIDE_W-1:0]  r_side [NST];

    logic               n_v    [NST];
    logic [REM_W-1:0]   n_rem  [NST];
    logic [NST-1:0]     n_root [NST];
    logic [RADIX_W-1:0] n_rad  [NST];
    logic [SIDE_W-1:0]  n_side [NST];

    always_comb begin
        logic [REM_W-1:0]   prem;
        logic [NST-1:0]     proot;
        logic [RADIX_W-1:0] prad;
        logic [REM_W-1:0]   rem_sh;
        logic [REM_W-1:0]   trial;
        logic               ge;
        for (int k = 0; k < NST; k++) begin
            if (k == 0) begin
                n_v[k]    = i_valid;
                n_side[k] = i_side;
                prem      = '0;
                proot     = '0;
                prad      = i_rad;
            end else begin
                n_v[k]    = r_v[k-1];
                n_side[k] = r_side[k-1];
                prem      = r_rem[k-1];
                proot     = r_root[k-1];
                prad      = r_rad[k-1];
            end
            rem_sh    = {prem[REM_W-3:0], prad[RADIX_W-1 -: 2]};
            trial     = {1'b0, proot, 2'b01};
            ge        = (rem_sh >= trial);
            n_rem[k]  = ge ? (rem_sh - trial) : rem_sh;
            n_root[k] = {proot[NST-2:0], ge};
            n_rad[k]  = {prad[RADIX_W-3:0], 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NST; k++) r_v[k] <= 1'b0;
        end else if (i_en) begin
            for (int k = 0; k < NST; k++) r_v[k] <= n_v[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NST; k++) begin
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
                r_rad[k]  <= n_rad[k];
                r_side[k] <= n_side[k];
            end
        end
    end

    assign o_valid = r_v[NST-1];
    assign o_root  = r_root[NST-1];
    assign o_side  = r_side[NST-1];

endmodule
`default_nettype wire

// ----- rtl/sps_div.sv -----
// sps_div: pipelined restoring divider, one quotient bit per stage, several lanes
// sharing one divisor. Dividend high half must be below the divisor.
`default_nettype none
module sps_div #(
    parameter int LANES  = 3,
    parameter int QW     = 32,
    parameter int DW     = 33,
    parameter int SIDE_W = 4
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_en,
    input  wire logic                i_valid,
    input  wire logic [2*QW-1:0]     i_num [LANES],
    input  wire logic [DW-1:0]       i_den,
    input  wire logic [SIDE_W-1:0]   i_side,
    output logic                     o_valid,
    output logic [QW-1:0]            o_q [LANES],
    output logic [SIDE_W-1:0]        o_side
);

    localparam int REM_W = DW + 1;

    logic              r_v    [QW];
    logic [REM_W-1:0]  r_rem  [QW][LANES];
    logic [QW-1:0]     r_lo   [QW][LANES];
    logic [DW-1:0]     r_den  [QW];
    logic [SIDE_W-1:0] r_side [QW];

    logic              n_v    [QW];
    logic [REM_W-1:0]  n_rem  [QW][LANES];
    logic [QW-1:0]     n_lo   [QW][LANES];
    logic [DW-1:0]     n_den  [QW];
    logic [SIDE_W-1:0] n_side [QW];

    always_comb begin
        logic [REM_W-1:0] prem;
        logic [QW-1:0]    plo;
        logic [DW-1:0]    pden;
        logic [REM_W-1:0] rem_sh;
        logic             ge;
        for (int k = 0; k < QW; k++) begin
            if (k == 0) begin
                n_v[k]    = i_valid;
                n_side[k] = i_side;
                pden      = i_den;
            end else begin
                n_v[k]    = r_v[k-1];
                n_side[k] = r_side[k-1];
                pden      = r_den[k-1];
            end
            n_den[k] = pden;
            for (int l = 0; l < LANES; l++) begin
                if (k == 0) begin
                    prem = {{(REM_W-QW){1'b0}}, i_num[l][2*QW-1:QW]};
                    plo  = i_num[l][QW-1:0];
                end else begin
                    prem = r_rem[k-1][l];
                    plo  = r_lo[k-1][l];
                end
                rem_sh      = {prem[REM_W-2:0], plo[QW-1]};
                ge          = (rem_sh >= {1'b0, pden});
                n_rem[k][l] = ge ? (rem_sh - {1'b0, pden}) : rem_sh;
                n_lo[k][l]  = {plo[QW-2:0], ge};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < QW; k++) r_v[k] <= 1'b0;
        end else if (i_en) begin
            for (int k = 0; k < QW; k++) r_v[k] <= n_v[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < QW; k++) begin
                r_den[k]  <= n_den[k];
                r_side[k] <= n_side[k];
                for (int l = 0; l < LANES; l++) begin
                    r_rem[k][l] <= n_rem[k][l];
                    r_lo[k][l]  <= n_lo[k][l];
                end
            end
        end
    end

    assign o_valid = r_v[QW-1];
    assign o_side  = r_side[QW-1];
    always_comb begin
        for (int l = 0; l < LANES; l++) o_q[l] = r_lo[QW-1][l];
    end

endmodule
`default_nettype wire
